// ===== hw/rtl/spfa_pkg.sv =====
// ----------------------------------------------------------------------------
// SPH pair force accumulator package
// Shared widths, command and register codes, controller types and the
// microprogram that orders the arithmetic of one neighbour pair.
// ----------------------------------------------------------------------------
package spfa_pkg;

  localparam int PARTICLES = 1024;
  localparam int IDX_W     = $clog2(PARTICLES);
  localparam int FRAC_BITS = 20;
  localparam int Q_W       = 40;
  localparam int RHO_W     = 39;
  localparam int CFG_W     = 39;
  localparam int CFG_IDX_W = 2;
  localparam int HALF_W    = Q_W / 2;
  localparam int PROD_W    = 2 * Q_W;
  localparam int NUM_W     = Q_W + FRAC_BITS;
  localparam int FIN_W     = 2 * Q_W + FRAC_BITS;
  localparam int DIV_STEPS = NUM_W;
  localparam int DCNT_W    = $clog2(DIV_STEPS);
  localparam int MEM_W     = 4 * Q_W + RHO_W;
  localparam int UOP_N     = 48;
  localparam int UPC_W     = $clog2(UOP_N);

  localparam logic signed [Q_W-1:0] QMAX = {1'b0, {(Q_W-1){1'b1}}};
  localparam logic signed [Q_W-1:0] QMIN = {1'b1, {(Q_W-1){1'b0}}};

  localparam logic [1:0] CMD_LOAD  = 2'd0;
  localparam logic [1:0] CMD_PAIR  = 2'd1;
  localparam logic [1:0] CMD_CLOSE = 2'd2;

  localparam logic [CFG_IDX_W-1:0] CFG_MASS = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_ETA  = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_VIS  = 2'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_FMT  = 2'd3;

  typedef enum logic [2:0] {OP_ADD, OP_SUB, OP_NEG, OP_MUL, OP_DIV} alu_op_t;

  typedef enum logic [2:0] {C_ALL, C_F0, C_F1, C_VF0, C_VF1, C_VIS} cond_t;

  typedef enum logic [4:0] {
    R_PI, R_PJ, R_RI, R_RJ, R_XXI, R_XXJ, R_XYI, R_XYJ, R_YYI, R_YYJ,
    R_GX, R_GY, R_ETA, R_MASS, R_SP, R_SXX, R_SXY, R_SYY, R_HX, R_HY,
    R_T, R_U, R_ACX, R_ACY
  } reg_id_t;

  typedef struct packed {
    cond_t   cond;
    alu_op_t op;
    reg_id_t dst;
    reg_id_t sa;
    reg_id_t sb;
  } uop_t;

  typedef enum logic [3:0] {
    S_IDLE, S_RD_I, S_RD_J, S_CAP_J, S_ISSUE, S_MUL_LO, S_MUL_HI, S_DIV,
    S_WB, S_FIN, S_EMIT
  } state_t;

  typedef struct packed {
    logic    latch_in;
    logic    mem_we;
    logic    rd_sel_j;
    logic    cap_i;
    logic    cap_j;
    logic    alu_load;
    alu_op_t op;
    reg_id_t sa;
    reg_id_t sb;
    logic    mul_lo;
    logic    mul_hi;
    logic    div_step;
    logic    wb;
    reg_id_t dst;
    logic    emit;
  } dp_cmd_t;

  function automatic uop_t mk(input cond_t c, input alu_op_t o, input reg_id_t d,
                              input reg_id_t a, input reg_id_t b);
    uop_t u;
    u.cond = c;
    u.op   = o;
    u.dst  = d;
    u.sa   = a;
    u.sb   = b;
    return u;
  endfunction

  // Pressure term, optional viscous stress terms, mass scaling, density
  // division for the density-product form, then the accumulator update.
  function automatic uop_t uop_rom(input logic [UPC_W-1:0] pc);
    uop_t u;
    case (pc)
      6'd0:  u = mk(C_F0,  OP_ADD, R_SP,  R_PI,  R_PJ);
      6'd1:  u = mk(C_F1,  OP_DIV, R_T,   R_PI,  R_RI);
      6'd2:  u = mk(C_F1,  OP_DIV, R_T,   R_T,   R_RI);
      6'd3:  u = mk(C_F1,  OP_DIV, R_U,   R_PJ,  R_RJ);
      6'd4:  u = mk(C_F1,  OP_DIV, R_U,   R_U,   R_RJ);
      6'd5:  u = mk(C_F1,  OP_ADD, R_SP,  R_T,   R_U);
      6'd6:  u = mk(C_ALL, OP_MUL, R_HX,  R_GX,  R_SP);
      6'd7:  u = mk(C_ALL, OP_NEG, R_HX,  R_HX,  R_HX);
      6'd8:  u = mk(C_ALL, OP_MUL, R_HY,  R_GY,  R_SP);
      6'd9:  u = mk(C_ALL, OP_NEG, R_HY,  R_HY,  R_HY);
      6'd10: u = mk(C_VF0, OP_ADD, R_SXX, R_XXI, R_XXJ);
      6'd11: u = mk(C_VF1, OP_DIV, R_T,   R_XXI, R_RI);
      6'd12: u = mk(C_VF1, OP_DIV, R_T,   R_T,   R_RI);
      6'd13: u = mk(C_VF1, OP_DIV, R_U,   R_XXJ, R_RJ);
      6'd14: u = mk(C_VF1, OP_DIV, R_U,   R_U,   R_RJ);
      6'd15: u = mk(C_VF1, OP_ADD, R_SXX, R_T,   R_U);
      6'd16: u = mk(C_VF0, OP_ADD, R_SXY, R_XYI, R_XYJ);
      6'd17: u = mk(C_VF1, OP_DIV, R_T,   R_XYI, R_RI);
      6'd18: u = mk(C_VF1, OP_DIV, R_T,   R_T,   R_RI);
      6'd19: u = mk(C_VF1, OP_DIV, R_U,   R_XYJ, R_RJ);
      6'd20: u = mk(C_VF1, OP_DIV, R_U,   R_U,   R_RJ);
      6'd21: u = mk(C_VF1, OP_ADD, R_SXY, R_T,   R_U);
      6'd22: u = mk(C_VF0, OP_ADD, R_SYY, R_YYI, R_YYJ);
      6'd23: u = mk(C_VF1, OP_DIV, R_T,   R_YYI, R_RI);
      6'd24: u = mk(C_VF1, OP_DIV, R_T,   R_T,   R_RI);
      6'd25: u = mk(C_VF1, OP_DIV, R_U,   R_YYJ, R_RJ);
      6'd26: u = mk(C_VF1, OP_DIV, R_U,   R_U,   R_RJ);
      6'd27: u = mk(C_VF1, OP_ADD, R_SYY, R_T,   R_U);
      6'd28: u = mk(C_VIS, OP_MUL, R_T,   R_SXX, R_GX);
      6'd29: u = mk(C_VIS, OP_MUL, R_T,   R_T,   R_ETA);
      6'd30: u = mk(C_VIS, OP_ADD, R_HX,  R_HX,  R_T);
      6'd31: u = mk(C_VIS, OP_MUL, R_T,   R_SXY, R_GY);
      6'd32: u = mk(C_VIS, OP_MUL, R_T,   R_T,   R_ETA);
      6'd33: u = mk(C_VIS, OP_ADD, R_HX,  R_HX,  R_T);
      6'd34: u = mk(C_VIS, OP_MUL, R_T,   R_SXY, R_GX);
      6'd35: u = mk(C_VIS, OP_MUL, R_T,   R_T,   R_ETA);
      6'd36: u = mk(C_VIS, OP_ADD, R_HY,  R_HY,  R_T);
      6'd37: u = mk(C_VIS, OP_MUL, R_T,   R_SYY, R_GY);
      6'd38: u = mk(C_VIS, OP_MUL, R_T,   R_T,   R_ETA);
      6'd39: u = mk(C_VIS, OP_ADD, R_HY,  R_HY,  R_T);
      6'd40: u = mk(C_ALL, OP_MUL, R_HX,  R_HX,  R_MASS);
      6'd41: u = mk(C_ALL, OP_MUL, R_HY,  R_HY,  R_MASS);
      6'd42: u = mk(C_F0,  OP_DIV, R_HX,  R_HX,  R_RI);
      6'd43: u = mk(C_F0,  OP_DIV, R_HX,  R_HX,  R_RJ);
      6'd44: u = mk(C_F0,  OP_DIV, R_HY,  R_HY,  R_RI);
      6'd45: u = mk(C_F0,  OP_DIV, R_HY,  R_HY,  R_RJ);
      6'd46: u = mk(C_ALL, OP_SUB, R_ACX, R_ACX, R_HX);
      default: u = mk(C_ALL, OP_SUB, R_ACY, R_ACY, R_HY);
    endcase
    return u;
  endfunction

endpackage

// ===== hw/rtl/spfa_ctrl.sv =====
// ----------------------------------------------------------------------------
// SPH pair force accumulator controller
// Handshakes, configuration flags, microprogram sequencing and the
// command word that drives the datapath.
// ----------------------------------------------------------------------------
module spfa_ctrl (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              in_valid,
  output logic                              in_ready,
  input  logic [1:0]                        in_command,
  input  logic                              in_last,
  output logic                              out_valid,
  input  logic                              out_ready,
  input  logic                              cfg_we,
  input  logic [spfa_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  logic                              cfg_bit,
  output spfa_pkg::dp_cmd_t                 cmd
);
  import spfa_pkg::*;

  state_t              state_r, state_nxt;
  logic [UPC_W-1:0]    pc_r, pc_nxt;
  logic [DCNT_W-1:0]   cnt_r, cnt_nxt;
  logic                last_r, last_nxt;
  logic                out_valid_r, out_valid_nxt;
  logic                fmt_r, vis_r;
  uop_t                u;
  logic                cond_ok;
  logic                pc_end;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      pc_r        <= '0;
      cnt_r       <= '0;
      last_r      <= 1'b0;
      out_valid_r <= 1'b0;
      fmt_r       <= 1'b0;
      vis_r       <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      pc_r        <= pc_nxt;
      cnt_r       <= cnt_nxt;
      last_r      <= last_nxt;
      out_valid_r <= out_valid_nxt;
      if (cfg_we && cfg_index == CFG_VIS) vis_r <= cfg_bit;
      if (cfg_we && cfg_index == CFG_FMT) fmt_r <= cfg_bit;
    end
  end

  assign u      = uop_rom(pc_r);
  assign pc_end = (pc_r == UPC_W'(UOP_N - 1));

  always_comb begin
    unique case (u.cond)
      C_ALL:   cond_ok = 1'b1;
      C_F0:    cond_ok = !fmt_r;
      C_F1:    cond_ok = fmt_r;
      C_VF0:   cond_ok = vis_r && !fmt_r;
      C_VF1:   cond_ok = vis_r && fmt_r;
      C_VIS:   cond_ok = vis_r;
      default: cond_ok = 1'b0;
    endcase
  end

  always_comb begin
    state_nxt     = state_r;
    pc_nxt        = pc_r;
    cnt_nxt       = cnt_r;
    last_nxt      = last_r;
    out_valid_nxt = out_valid_r && !out_ready;
    in_ready      = 1'b0;
    cmd           = '0;
    cmd.op        = u.op;
    cmd.sa        = u.sa;
    cmd.sb        = u.sb;
    cmd.dst       = u.dst;

    unique case (state_r)
      S_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.latch_in = 1'b1;
          last_nxt     = in_last;
          case (in_command)
            CMD_LOAD:  cmd.mem_we = 1'b1;
            CMD_PAIR:  state_nxt  = S_RD_I;
            CMD_CLOSE: state_nxt  = S_EMIT;
            default:   state_nxt  = S_IDLE;
          endcase
        end
      end
      S_RD_I: begin
        state_nxt = S_RD_J;
      end
      S_RD_J: begin
        cmd.rd_sel_j = 1'b1;
        cmd.cap_i    = 1'b1;
        state_nxt    = S_CAP_J;
      end
      S_CAP_J: begin
        cmd.cap_j = 1'b1;
        pc_nxt    = '0;
        state_nxt = S_ISSUE;
      end
      S_ISSUE: begin
        if (cond_ok) begin
          cmd.alu_load = 1'b1;
          cnt_nxt      = '0;
          case (u.op)
            OP_MUL:  state_nxt = S_MUL_LO;
            OP_DIV:  state_nxt = S_DIV;
            default: state_nxt = S_WB;
          endcase
        end else if (pc_end) begin
          state_nxt = S_FIN;
        end else begin
          pc_nxt = pc_r + 1'b1;
        end
      end
      S_MUL_LO: begin
        cmd.mul_lo = 1'b1;
        state_nxt  = S_MUL_HI;
      end
      S_MUL_HI: begin
        cmd.mul_hi = 1'b1;
        state_nxt  = S_WB;
      end
      S_DIV: begin
        cmd.div_step = 1'b1;
        cnt_nxt      = cnt_r + 1'b1;
        if (cnt_r == DCNT_W'(DIV_STEPS - 1)) state_nxt = S_WB;
      end
      S_WB: begin
        cmd.wb = 1'b1;
        if (pc_end) begin
          state_nxt = S_FIN;
        end else begin
          pc_nxt    = pc_r + 1'b1;
          state_nxt = S_ISSUE;
        end
      end
      S_FIN: begin
        state_nxt = last_r ? S_EMIT : S_IDLE;
      end
      S_EMIT: begin
        // The result register must be empty or emptying this cycle.
        if (!out_valid_r || out_ready) begin
          cmd.emit      = 1'b1;
          out_valid_nxt = 1'b1;
          state_nxt     = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  assign out_valid = out_valid_r;

endmodule

// ===== hw/rtl/spfa_dp.sv =====
// ----------------------------------------------------------------------------
// SPH pair force accumulator datapath
// Particle record memory, operand registers, a saturating Q20.20 unit with
// a split multiplier and a bit-serial divider, accumulators and result.
// ----------------------------------------------------------------------------
module spfa_dp (
  input  logic                                  clk,
  input  logic                                  rst_n,
  input  spfa_pkg::dp_cmd_t                     cmd,
  input  logic [spfa_pkg::IDX_W-1:0]            in_particle_index,
  input  logic [spfa_pkg::IDX_W-1:0]            in_neighbour_index,
  input  logic signed [spfa_pkg::Q_W-1:0]       in_grad_x,
  input  logic signed [spfa_pkg::Q_W-1:0]       in_grad_y,
  input  logic signed [spfa_pkg::Q_W-1:0]       in_pressure,
  input  logic [spfa_pkg::RHO_W-1:0]            in_density,
  input  logic signed [spfa_pkg::Q_W-1:0]       in_stress_xx,
  input  logic signed [spfa_pkg::Q_W-1:0]       in_stress_xy,
  input  logic signed [spfa_pkg::Q_W-1:0]       in_stress_yy,
  input  logic                                  cfg_we,
  input  logic [spfa_pkg::CFG_IDX_W-1:0]        cfg_index,
  input  logic [spfa_pkg::CFG_W-1:0]            cfg_data,
  output logic [spfa_pkg::IDX_W-1:0]            out_result_index,
  output logic signed [spfa_pkg::Q_W-1:0]       out_accel_x,
  output logic signed [spfa_pkg::Q_W-1:0]       out_accel_y,
  output logic                                  out_saturated
);
  import spfa_pkg::*;

  logic [MEM_W-1:0] mem [PARTICLES];
  logic [MEM_W-1:0] rd_q_r;
  logic [IDX_W-1:0] rd_addr;

  logic [IDX_W-1:0]        j_r, i_r;
  logic signed [Q_W-1:0]   gx_r, gy_r;
  logic [CFG_W-1:0]        mass_r, eta_r;
  logic signed [Q_W-1:0]   pi_r, pj_r, ri_r, rj_r;
  logic signed [Q_W-1:0]   xxi_r, xxj_r, xyi_r, xyj_r, yyi_r, yyj_r;
  logic signed [Q_W-1:0]   sp_r, sxx_r, sxy_r, syy_r, hx_r, hy_r, t_r, u_r;
  logic signed [Q_W-1:0]   acx_r, acy_r;
  logic                    sat_r;

  logic signed [Q_W-1:0]   a_r, b_r;
  alu_op_t                 op_r;
  logic [Q_W-1:0]          ma_r, mb_r;
  logic                    neg_r, za_r, zb_r;
  logic [PROD_W-1:0]       prod_r;
  logic [NUM_W-1:0]        qn_r;
  logic [Q_W-1:0]          rem_r;

  logic signed [Q_W-1:0]   opa, opb;
  logic [Q_W-1:0]          ma, mb;
  logic [Q_W+HALF_W-1:0]   pp;
  logic [Q_W:0]            r2;
  logic                    qbit;
  logic signed [Q_W:0]     s41;
  logic [FIN_W-1:0]        mag;
  logic signed [Q_W-1:0]   res;
  logic                    res_sat;

  function automatic logic [Q_W-1:0] qmag(input logic signed [Q_W-1:0] v);
    return v[Q_W-1] ? Q_W'(-v) : Q_W'(v);
  endfunction

  function automatic logic signed [Q_W-1:0] opnd(input reg_id_t id);
    logic signed [Q_W-1:0] v;
    unique case (id)
      R_PI:    v = pi_r;
      R_PJ:    v = pj_r;
      R_RI:    v = ri_r;
      R_RJ:    v = rj_r;
      R_XXI:   v = xxi_r;
      R_XXJ:   v = xxj_r;
      R_XYI:   v = xyi_r;
      R_XYJ:   v = xyj_r;
      R_YYI:   v = yyi_r;
      R_YYJ:   v = yyj_r;
      R_GX:    v = gx_r;
      R_GY:    v = gy_r;
      R_ETA:   v = Q_W'(eta_r);
      R_MASS:  v = Q_W'(mass_r);
      R_SP:    v = sp_r;
      R_SXX:   v = sxx_r;
      R_SXY:   v = sxy_r;
      R_SYY:   v = syy_r;
      R_HX:    v = hx_r;
      R_HY:    v = hy_r;
      R_T:     v = t_r;
      R_U:     v = u_r;
      R_ACX:   v = acx_r;
      R_ACY:   v = acy_r;
      default: v = '0;
    endcase
    return v;
  endfunction

  // Particle record memory: one write port for loads, one registered read.
  assign rd_addr = cmd.rd_sel_j ? j_r : i_r;

  always_ff @(posedge clk) begin
    if (cmd.mem_we) begin
      mem[in_particle_index] <= {in_pressure, in_density, in_stress_xx,
                                 in_stress_xy, in_stress_yy};
    end
    rd_q_r <= mem[rd_addr];
  end

  assign opa = opnd(cmd.sa);
  assign opb = opnd(cmd.sb);
  assign ma  = qmag(opa);
  assign mb  = qmag(opb);

  // One 40x20 multiplier serves both halves of the multiplier operand.
  assign pp = ma_r * (cmd.mul_hi ? mb_r[Q_W-1:HALF_W] : mb_r[HALF_W-1:0]);

  assign r2   = {rem_r, qn_r[NUM_W-1]};
  assign qbit = (r2 >= {1'b0, mb_r});

  always_comb begin
    s41 = '0;
    mag = '0;
    res = '0;
    res_sat = 1'b0;
    case (op_r) inside
      OP_ADD, OP_SUB, OP_NEG: begin
        if (op_r == OP_ADD)      s41 = {a_r[Q_W-1], a_r} + {b_r[Q_W-1], b_r};
        else if (op_r == OP_SUB) s41 = {a_r[Q_W-1], a_r} - {b_r[Q_W-1], b_r};
        else                     s41 = '0 - {a_r[Q_W-1], a_r};
        if (s41[Q_W] != s41[Q_W-1]) begin
          res_sat = 1'b1;
          res     = s41[Q_W] ? QMIN : QMAX;
        end else begin
          res = s41[Q_W-1:0];
        end
      end
      default: begin
        if (op_r == OP_MUL) mag = FIN_W'(prod_r[PROD_W-1:FRAC_BITS]);
        else                mag = FIN_W'(qn_r);
        if (op_r == OP_DIV && zb_r) begin
          // Division by zero saturates toward the numerator's sign; zero over zero gives zero.
          res_sat = !za_r;
          res     = za_r ? '0 : (neg_r ? QMIN : QMAX);
        end else if (neg_r) begin
          if (mag > (FIN_W'(1) << (Q_W - 1))) begin
            res_sat = 1'b1;
            res     = QMIN;
          end else begin
            res = Q_W'(-mag[Q_W-1:0]);
          end
        end else begin
          if (mag > FIN_W'(QMAX)) begin
            res_sat = 1'b1;
            res     = QMAX;
          end else begin
            res = mag[Q_W-1:0];
          end
        end
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (cmd.latch_in) begin
      j_r  <= in_particle_index;
      i_r  <= in_neighbour_index;
      gx_r <= in_grad_x;
      gy_r <= in_grad_y;
    end
    if (cmd.cap_i) begin
      {pi_r, ri_r, xxi_r, xyi_r, yyi_r} <= {rd_q_r[MEM_W-1 -: Q_W], 1'b0,
                                           rd_q_r[3*Q_W +: RHO_W], rd_q_r[3*Q_W-1:0]};
    end
    if (cmd.cap_j) begin
      {pj_r, rj_r, xxj_r, xyj_r, yyj_r} <= {rd_q_r[MEM_W-1 -: Q_W], 1'b0,
                                           rd_q_r[3*Q_W +: RHO_W], rd_q_r[3*Q_W-1:0]};
    end
    if (cmd.alu_load) begin
      op_r   <= cmd.op;
      a_r    <= opa;
      b_r    <= opb;
      ma_r   <= ma;
      mb_r   <= mb;
      neg_r  <= opa[Q_W-1] ^ opb[Q_W-1];
      za_r   <= (ma == '0);
      zb_r   <= (mb == '0);
      qn_r   <= {ma, FRAC_BITS'(0)};
      rem_r  <= '0;
    end
    if (cmd.mul_lo) prod_r <= PROD_W'(pp);
    if (cmd.mul_hi) prod_r <= prod_r + {pp, HALF_W'(0)};
    if (cmd.div_step) begin
      rem_r <= qbit ? Q_W'(r2 - {1'b0, mb_r}) : r2[Q_W-1:0];
      qn_r  <= {qn_r[NUM_W-2:0], qbit};
    end
    if (cmd.wb) begin
      case (cmd.dst)
        R_SP:    sp_r  <= res;
        R_SXX:   sxx_r <= res;
        R_SXY:   sxy_r <= res;
        R_SYY:   syy_r <= res;
        R_HX:    hx_r  <= res;
        R_HY:    hy_r  <= res;
        R_T:     t_r   <= res;
        R_U:     u_r   <= res;
        default: ;
      endcase
    end
    if (cmd.emit) begin
      out_result_index <= j_r;
      out_accel_x      <= acx_r;
      out_accel_y      <= acy_r;
      out_saturated    <= sat_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      acx_r  <= '0;
      acy_r  <= '0;
      sat_r  <= 1'b0;
      mass_r <= '0;
      eta_r  <= '0;
    end else begin
      if (cfg_we && cfg_index == CFG_MASS) mass_r <= cfg_data;
      if (cfg_we && cfg_index == CFG_ETA)  eta_r  <= cfg_data;
      if (cmd.emit) begin
        acx_r <= '0;
        acy_r <= '0;
        sat_r <= 1'b0;
      end else if (cmd.wb) begin
        sat_r <= sat_r | res_sat;
        if (cmd.dst == R_ACX) acx_r <= res;
        if (cmd.dst == R_ACY) acy_r <= res;
      end
    end
  end

endmodule

// ===== hw/rtl/sph_pair_force_accumulate_core.sv =====
// Load item: written to the record memory on acceptance. Pair item: record reads, then 48
// program steps (skipped, add/subtract/negate, multiply in halves, bit-serial divide), then
// a finish step and an emit when in_last is set. Close item: emit only. One item is worked
// on at a time; the result register is freed while the next item runs. Reset (rst_n low,
// synchronous) clears the accumulators, flag, configuration and handshakes; the record
// memory is not cleared.
// ----------------------------------------------------------------------------
// SPH pair force accumulator top level
// Loads particle records and sums the pressure and viscous pair forces of a
// particle into a saturating Q20.20 acceleration.
// ----------------------------------------------------------------------------
module sph_pair_force_accumulate_core (
  input  logic                                  clk,
  input  logic                                  rst_n,
  input  logic                                  in_valid,
  output logic                                  in_ready,
  input  logic [1:0]                            in_command,
  input  logic [spfa_pkg::IDX_W-1:0]            in_particle_index,
  input  logic [spfa_pkg::IDX_W-1:0]            in_neighbour_index,
  input  logic signed [spfa_pkg::Q_W-1:0]       in_grad_x,
  input  logic signed [spfa_pkg::Q_W-1:0]       in_grad_y,
  input  logic signed [spfa_pkg::Q_W-1:0]       in_pressure,
  input  logic [spfa_pkg::RHO_W-1:0]            in_density,
  input  logic signed [spfa_pkg::Q_W-1:0]       in_stress_xx,
  input  logic signed [spfa_pkg::Q_W-1:0]       in_stress_xy,
  input  logic signed [spfa_pkg::Q_W-1:0]       in_stress_yy,
  input  logic                                  in_last,
  output logic                                  out_valid,
  input  logic                                  out_ready,
  output logic [spfa_pkg::IDX_W-1:0]            out_result_index,
  output logic signed [spfa_pkg::Q_W-1:0]       out_accel_x,
  output logic signed [spfa_pkg::Q_W-1:0]       out_accel_y,
  output logic                                  out_saturated,
  input  logic                                  cfg_we,
  input  logic [spfa_pkg::CFG_IDX_W-1:0]        cfg_index,
  input  logic [spfa_pkg::CFG_W-1:0]            cfg_data
);
  import spfa_pkg::*;

  dp_cmd_t cmd;

  spfa_ctrl u_ctrl (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (in_valid),
    .in_ready   (in_ready),
    .in_command (in_command),
    .in_last    (in_last),
    .out_valid  (out_valid),
    .out_ready  (out_ready),
    .cfg_we     (cfg_we),
    .cfg_index  (cfg_index),
    .cfg_bit    (cfg_data[0]),
    .cmd        (cmd)
  );

  spfa_dp u_dp (
    .clk                (clk),
    .rst_n              (rst_n),
    .cmd                (cmd),
    .in_particle_index  (in_particle_index),
    .in_neighbour_index (in_neighbour_index),
    .in_grad_x          (in_grad_x),
    .in_grad_y          (in_grad_y),
    .in_pressure        (in_pressure),
    .in_density         (in_density),
    .in_stress_xx       (in_stress_xx),
    .in_stress_xy       (in_stress_xy),
    .in_stress_yy       (in_stress_yy),
    .cfg_we             (cfg_we),
    .cfg_index          (cfg_index),
    .cfg_data           (cfg_data),
    .out_result_index   (out_result_index),
    .out_accel_x        (out_accel_x),
    .out_accel_y        (out_accel_y),
    .out_saturated      (out_saturated)
  );

endmodule

// ===== hw/rtl/spfa_checker.sv =====
// ----------------------------------------------------------------------------
// SPH pair force accumulator port checker
// Watches the top-level ports for handshake and sequencing properties.
// ----------------------------------------------------------------------------
module spfa_checker (
  input logic                                  clk,
  input logic                                  rst_n,
  input logic                                  in_valid,
  input logic                                  in_ready,
  input logic [1:0]                            in_command,
  input logic                                  out_valid,
  input logic                                  out_ready,
  input logic [spfa_pkg::IDX_W-1:0]            out_result_index,
  input logic signed [spfa_pkg::Q_W-1:0]       out_accel_x,
  input logic signed [spfa_pkg::Q_W-1:0]       out_accel_y,
  input logic                                  out_saturated
);
  import spfa_pkg::*;

  // A stalled result holds its value until the transfer.
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_accel_x) &&
      $stable(out_accel_y) && $stable(out_result_index) && $stable(out_saturated))
    else $error("stalled result changed");

  a_reset_empty: assert property (@(posedge clk) !rst_n |=> !out_valid)
    else $error("result valid after reset");

  // After accepting a pair or close item, the block deasserts in_ready.
  a_busy_after_work: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready && (in_command == CMD_PAIR || in_command == CMD_CLOSE)
      |=> !in_ready)
    else $error("ready right after pair or close");

  // A load never produces a result.
  a_load_silent: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready && in_command == CMD_LOAD && !out_valid |=> !out_valid)
    else $error("load produced a result");

endmodule

bind sph_pair_force_accumulate_core spfa_checker u_spfa_checker (.*);

// ===== dv/tb_sph_pair_force_accumulate_core.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// SPH pair force accumulator testbench
// Loads particle records, streams neighbour pairs and closes with and without random
// handshake idling, and checks every acceleration against a fixed-point
// force summation kept inside the bench.
// ----------------------------------------------------------------------------
module tb_sph_pair_force_accumulate_core;
  import spfa_pkg::*;

  typedef logic signed [Q_W-1:0] q_t;
  typedef logic [127:0] wide_t;

  typedef struct {
    logic [IDX_W-1:0] index;
    q_t               ax;
    q_t               ay;
    logic             sat;
  } accel_t;

  localparam int LIMIT_CYCLES = 4000000;
  localparam int DRAIN_CYCLES = 1300;

  // Command code with no meaning; the block ignores it.
  localparam logic [1:0] CMD_UNUSED = 2'd3;

  logic                 clk;
  logic                 rst_n;
  logic                 in_valid;
  logic                 in_ready;
  logic [1:0]           in_command;
  logic [IDX_W-1:0]     in_particle_index;
  logic [IDX_W-1:0]     in_neighbour_index;
  q_t                   in_grad_x;
  q_t                   in_grad_y;
  q_t                   in_pressure;
  logic [RHO_W-1:0]     in_density;
  q_t                   in_stress_xx;
  q_t                   in_stress_xy;
  q_t                   in_stress_yy;
  logic                 in_last;
  logic                 out_valid;
  logic                 out_ready;
  logic [IDX_W-1:0]     out_result_index;
  q_t                   out_accel_x;
  q_t                   out_accel_y;
  logic                 out_saturated;
  logic                 cfg_we;
  logic [CFG_IDX_W-1:0] cfg_index;
  logic [CFG_W-1:0]     cfg_data;

  sph_pair_force_accumulate_core dut (.*);

  // Bench copy of the block state.
  q_t               pres_tab [PARTICLES];
  q_t               rho_tab  [PARTICLES];
  q_t               sxx_tab  [PARTICLES];
  q_t               sxy_tab  [PARTICLES];
  q_t               syy_tab  [PARTICLES];
  q_t               acc_x, acc_y;
  logic             acc_sat;
  logic [CFG_W-1:0] mass_reg, eta_reg;
  logic             vis_reg, form_reg;

  logic [IDX_W-1:0] loaded_ids[$];
  bit               is_loaded[PARTICLES];
  accel_t           expected_accels[$];
  int               mismatch_count;
  int               cycle_count;
  bit               tx_idle_on;
  bit               rx_idle_on;
  bit               rx_hold;
  int               rx_hold_len;

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // ---------------- fixed-point arithmetic ----------------
  function automatic q_t q_clamp(input logic signed [127:0] v);
    if (v > $signed({88'd0, QMAX})) begin
      acc_sat = 1'b1;
      return QMAX;
    end
    if (v < -$signed(129'd549755813888)) begin
      acc_sat = 1'b1;
      return QMIN;
    end
    return v[Q_W-1:0];
  endfunction

  function automatic wide_t q_mag(input q_t a);
    logic signed [127:0] s;
    s = a;
    return (s < 0) ? wide_t'(-s) : wide_t'(s);
  endfunction

  function automatic q_t q_finish(input logic neg, input wide_t m);
    if (neg) begin
      if (m > (wide_t'(1) << 39)) begin
        acc_sat = 1'b1;
        return QMIN;
      end
      return -m[Q_W-1:0];
    end
    if (m > wide_t'(QMAX)) begin
      acc_sat = 1'b1;
      return QMAX;
    end
    return m[Q_W-1:0];
  endfunction

  function automatic q_t q_add(input q_t a, input q_t b);
    return q_clamp(128'(a) + 128'(b));
  endfunction

  function automatic q_t q_mul(input q_t a, input q_t b);
    return q_finish(a[Q_W-1] ^ b[Q_W-1], (q_mag(a) * q_mag(b)) >> FRAC_BITS);
  endfunction

  function automatic q_t q_div(input q_t a, input q_t d);
    wide_t ma, md;
    ma = q_mag(a);
    md = q_mag(d);
    if (md == 0) begin
      if (ma == 0) return '0;
      acc_sat = 1'b1;
      return (a[Q_W-1] ^ d[Q_W-1]) ? QMIN : QMAX;
    end
    return q_finish(a[Q_W-1] ^ d[Q_W-1], (ma << FRAC_BITS) / md);
  endfunction

  // Sum of a neighbour and particle quantity in the selected formulation.
  function automatic q_t pair_total(input q_t ti, input q_t tj, input q_t ri, input q_t rj);
    if (!form_reg) return q_add(ti, tj);
    return q_add(q_div(q_div(ti, ri), ri), q_div(q_div(tj, rj), rj));
  endfunction

  function automatic void add_pair_force(input int j, input int i, input q_t gx, input q_t gy);
    q_t ri, rj, eta, mass, sp, hx, hy, txx, txy, tyy, dx, dy;
    ri   = rho_tab[i];
    rj   = rho_tab[j];
    eta  = q_t'(eta_reg);
    mass = q_t'(mass_reg);
    sp   = pair_total(pres_tab[i], pres_tab[j], ri, rj);
    hx   = q_clamp(-128'(q_mul(gx, sp)));
    hy   = q_clamp(-128'(q_mul(gy, sp)));
    if (vis_reg) begin
      txx = pair_total(sxx_tab[i], sxx_tab[j], ri, rj);
      txy = pair_total(sxy_tab[i], sxy_tab[j], ri, rj);
      tyy = pair_total(syy_tab[i], syy_tab[j], ri, rj);
      hx  = q_add(hx, q_mul(q_mul(txx, gx), eta));
      hx  = q_add(hx, q_mul(q_mul(txy, gy), eta));
      hy  = q_add(hy, q_mul(q_mul(txy, gx), eta));
      hy  = q_add(hy, q_mul(q_mul(tyy, gy), eta));
    end
    dx = q_mul(hx, mass);
    dy = q_mul(hy, mass);
    if (!form_reg) begin
      dx = q_div(q_div(dx, ri), rj);
      dy = q_div(q_div(dy, ri), rj);
    end
    acc_x = q_clamp(128'(acc_x) - 128'(dx));
    acc_y = q_clamp(128'(acc_y) - 128'(dy));
  endfunction

  function automatic void queue_accel(input logic [IDX_W-1:0] idx);
    accel_t a;
    a.index = idx;
    a.ax    = acc_x;
    a.ay    = acc_y;
    a.sat   = acc_sat;
    expected_accels.push_back(a);
    acc_x   = '0;
    acc_y   = '0;
    acc_sat = 1'b0;
  endfunction

  // Applies one accepted transfer to the bench state.
  function automatic void predict_transfer();
    int j, i;
    j = in_particle_index;
    i = in_neighbour_index;
    case (in_command)
      CMD_LOAD: begin
        pres_tab[j] = in_pressure;
        rho_tab[j]  = q_t'(in_density);
        sxx_tab[j]  = in_stress_xx;
        sxy_tab[j]  = in_stress_xy;
        syy_tab[j]  = in_stress_yy;
      end
      CMD_PAIR: begin
        add_pair_force(j, i, in_grad_x, in_grad_y);
        if (in_last) queue_accel(in_particle_index);
      end
      CMD_CLOSE: queue_accel(in_particle_index);
      default: ;
    endcase
  endfunction

  // ---------------- drivers ----------------
  task automatic send_item(input logic [1:0] cmd, input int j, input int i,
                           input q_t gx, input q_t gy, input q_t p,
                           input logic [RHO_W-1:0] rho, input q_t txx,
                           input q_t txy, input q_t tyy, input logic lst);
    in_valid           <= 1'b1;
    in_command         <= cmd;
    in_particle_index  <= IDX_W'(j);
    in_neighbour_index <= IDX_W'(i);
    in_grad_x          <= gx;
    in_grad_y          <= gy;
    in_pressure        <= p;
    in_density         <= rho;
    in_stress_xx       <= txx;
    in_stress_xy       <= txy;
    in_stress_yy       <= tyy;
    in_last            <= lst;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    predict_transfer();
    if (cmd == CMD_LOAD && !is_loaded[j]) begin
      is_loaded[j] = 1'b1;
      loaded_ids.push_back(IDX_W'(j));
    end
    if (tx_idle_on && $urandom_range(0, 3) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 8)) @(posedge clk);
    end
  endtask

  function automatic q_t rand_q();
    q_t v;
    v = Q_W'({$urandom(), $urandom()});
    if ($urandom_range(0, 3) != 0) v = $signed(v[25:0]);
    return v;
  endfunction

  function automatic logic [RHO_W-1:0] rand_rho();
    logic [RHO_W-1:0] r;
    r = RHO_W'({$urandom(), $urandom()});
    if ($urandom_range(0, 3) != 0) r = $urandom_range(1 << 18, 1 << 22);
    if (r == 0) r = 1;
    return r;
  endfunction

  task automatic send_load(input int j);
    send_item(CMD_LOAD, j, $urandom_range(0, 1023), rand_q(), rand_q(), rand_q(),
              rand_rho(), rand_q(), rand_q(), rand_q(), 1'($urandom_range(0, 1)));
  endtask

  task automatic send_pair(input int j, input int i, input q_t gx, input q_t gy,
                           input logic lst);
    send_item(CMD_PAIR, j, i, gx, gy, rand_q(), rand_rho(), rand_q(), rand_q(),
              rand_q(), lst);
  endtask

  task automatic send_close(input int j);
    send_item(CMD_CLOSE, j, $urandom_range(0, 1023), rand_q(), rand_q(), rand_q(),
              rand_rho(), rand_q(), rand_q(), rand_q(), 1'($urandom_range(0, 1)));
  endtask

  // Drains the block so registers may be rewritten.
  task automatic wait_idle();
    in_valid <= 1'b0;
    @(posedge clk);
    while (expected_accels.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic write_cfg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_W-1:0] val);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    @(posedge clk);
    cfg_we <= 1'b0;
    case (idx)
      CFG_MASS: mass_reg = val;
      CFG_ETA:  eta_reg  = val;
      CFG_VIS:  vis_reg  = val[0];
      default:  form_reg = val[0];
    endcase
  endtask

  task automatic set_config(input logic [CFG_W-1:0] mass, input logic [CFG_W-1:0] eta,
                            input logic vis, input logic form);
    wait_idle();
    write_cfg(CFG_MASS, mass);
    write_cfg(CFG_ETA, eta);
    write_cfg(CFG_VIS, CFG_W'(vis));
    write_cfg(CFG_FMT, CFG_W'(form));
  endtask

  // Mostly well-formed neighbour lists over loaded particles, plus noise.
  task automatic random_stream(input int n);
    int k, sel, j;
    for (k = 0; k < n; k++) begin
      sel = $urandom_range(0, 99);
      if (sel < 20 || loaded_ids.size() < 2) send_load($urandom_range(0, 1023));
      else if (sel < 88) begin
        j = loaded_ids[$urandom_range(0, loaded_ids.size() - 1)];
        send_pair(j, loaded_ids[$urandom_range(0, loaded_ids.size() - 1)], rand_q(),
                  rand_q(), $urandom_range(0, 3) == 0);
      end else if (sel < 96) send_close($urandom_range(0, 1023));
      else send_item(CMD_UNUSED, $urandom_range(0, 1023), $urandom_range(0, 1023),
                     rand_q(), rand_q(), rand_q(), rand_rho(), rand_q(), rand_q(),
                     rand_q(), 1'b1);
    end
  endtask

  // ---------------- tests ----------------
  task automatic test_directed();
    set_config(39'd1 << FRAC_BITS, 39'd1 << (FRAC_BITS - 2), 1'b0, 1'b0);
    send_item(CMD_LOAD, 0, 0, '0, '0, QMAX, 39'h7fffffffff, QMIN, QMAX, QMIN, 1'b0);
    send_item(CMD_LOAD, 1023, 0, '0, '0, QMIN, 39'd1, QMAX, QMIN, QMAX, 1'b1);
    send_item(CMD_LOAD, 5, 0, '0, '0, 40'sd3 << 20, 39'd1 << 20, 40'sd1 << 19,
              -(40'sd1 << 18), 40'sd5 << 16, 1'b0);
    // A zero density must saturate the quotient.
    send_item(CMD_LOAD, 6, 0, '0, '0, 40'sd7 << 20, 39'd0, '0, '0, '0, 1'b0);
    send_close(17);
    send_pair(5, 5, 40'sd1 << 20, -(40'sd1 << 20), 1'b1);
    send_pair(0, 1023, QMAX, QMIN, 1'b1);
    send_pair(1023, 0, QMIN, QMAX, 1'b0);
    // Pairs of different particles keep summing, then a close emits the total.
    send_pair(5, 0, 40'sd1 << 20, 40'sd1 << 20, 1'b0);
    send_close(5);
    send_pair(5, 6, 40'sd1 << 20, 40'sd1 << 20, 1'b1);
    send_item(CMD_UNUSED, 5, 5, '0, '0, '0, 39'd1, '0, '0, '0, 1'b1);
    send_pair(5, 5, '0, '0, 1'b1);
    set_config(39'h7fffffffff, 39'h7fffffffff, 1'b1, 1'b1);
    send_pair(5, 5, 40'sd1 << 20, 40'sd1 << 19, 1'b1);
    send_pair(0, 1023, QMAX, QMIN, 1'b1);
    send_pair(5, 6, 40'sd1 << 20, 40'sd1 << 20, 1'b1);
    send_pair(1023, 5, -(40'sd1 << 20), 40'sd1, 1'b1);
  endtask

  task automatic test_config_sweep();
    set_config(39'd1 << FRAC_BITS, 39'd1 << (FRAC_BITS - 1), 1'b1, 1'b0);
    random_stream(120);
    set_config(39'd3 << (FRAC_BITS - 2), 39'd0, 1'b0, 1'b1);
    random_stream(120);
    set_config(39'd0, 39'h7fffffffff, 1'b1, 1'b1);
    random_stream(60);
    set_config($urandom_range(1, 1 << 24), $urandom_range(1, 1 << 22), 1'b1, 1'b1);
    random_stream(140);
  endtask

  // The receiver stalls while fast closes pile up behind the pending result.
  task automatic test_backpressure();
    int k;
    set_config(39'd1 << FRAC_BITS, 39'd1 << FRAC_BITS, 1'b0, 1'b0);
    rx_hold_len = 2000;
    rx_hold     = 1'b1;
    for (k = 0; k < 20; k++) send_close($urandom_range(0, 1023));
    random_stream(60);
  endtask

  task automatic test_no_idle();
    wait_idle();
    tx_idle_on = 1'b0;
    rx_idle_on = 1'b0;
    random_stream(160);
  endtask

  // ---------------- receiver and checker ----------------
  initial begin
    out_ready <= 1'b0;
    @(posedge clk);
    forever begin
      if (rx_hold) begin
        out_ready <= 1'b0;
        repeat (rx_hold_len) @(posedge clk);
        rx_hold = 1'b0;
      end else if (rx_idle_on && $urandom_range(0, 5) == 0) begin
        out_ready <= 1'b0;
        repeat ($urandom_range(1, 8)) @(posedge clk);
      end else begin
        out_ready <= 1'b1;
        @(posedge clk);
      end
    end
  end

  task automatic report_mismatch(input string what);
    $display("[%0t] %s", $realtime, what);
    mismatch_count++;
  endtask

  always @(posedge clk) begin
    accel_t e;
    if (rst_n && out_valid && out_ready) begin
      if (expected_accels.size() == 0) report_mismatch("unexpected acceleration result");
      else begin
        e = expected_accels.pop_front();
        if (out_result_index !== e.index)
          report_mismatch($sformatf("index got %0d want %0d", out_result_index, e.index));
        if (out_accel_x !== e.ax)
          report_mismatch($sformatf("accel_x got %0d want %0d", out_accel_x, e.ax));
        if (out_accel_y !== e.ay)
          report_mismatch($sformatf("accel_y got %0d want %0d", out_accel_y, e.ay));
        if (out_saturated !== e.sat)
          report_mismatch($sformatf("saturated got %0b want %0b", out_saturated, e.sat));
      end
    end
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > LIMIT_CYCLES) begin
      $display("Mismatches found");
      $finish;
    end
  end

  initial begin
    cycle_count    = 0;
    mismatch_count = 0;
    tx_idle_on     = 1'b1;
    rx_idle_on     = 1'b1;
    rx_hold        = 1'b0;
    rx_hold_len    = 0;
    acc_x = '0; acc_y = '0; acc_sat = 1'b0;
    mass_reg = '0; eta_reg = '0; vis_reg = 1'b0; form_reg = 1'b0;
    rst_n              <= 1'b0;
    in_valid           <= 1'b0;
    in_command         <= CMD_LOAD;
    in_particle_index  <= '0;
    in_neighbour_index <= '0;
    in_grad_x          <= '0;
    in_grad_y          <= '0;
    in_pressure        <= '0;
    in_density         <= '0;
    in_stress_xx       <= '0;
    in_stress_xy       <= '0;
    in_stress_yy       <= '0;
    in_last            <= 1'b0;
    cfg_we             <= 1'b0;
    cfg_index          <= CFG_MASS;
    cfg_data           <= '0;
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_directed();
    test_config_sweep();
    test_backpressure();
    test_no_idle();
    wait_idle();
    if (mismatch_count == 0 && expected_accels.size() == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

endmodule

// ===== sim.f =====
hw/rtl/spfa_pkg.sv
hw/rtl/spfa_ctrl.sv
hw/rtl/spfa_dp.sv
hw/rtl/sph_pair_force_accumulate_core.sv
hw/rtl/spfa_checker.sv
dv/tb_sph_pair_force_accumulate_core.sv
